// ===== hw/rtl/ccse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cyclic code systematic encoder package
// Shared widths, register indexes and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ccse_pkg;

	localparam int CCSE_MAX_N   = 64;
	localparam int CCSE_N_W     = 7;
	localparam int CCSE_K_W     = 6;
	localparam int CCSE_POLY_W  = 63;
	localparam int CCSE_MSG_W   = 63;
	localparam int CCSE_CW_W    = 64;
	localparam int CCSE_DATA_W  = 64;
	localparam int CCSE_ADDR_W  = 5;
	localparam int CCSE_IDX_W   = 2;

	typedef enum logic [CCSE_IDX_W-1:0] {
		REG_CODE_LENGTH    = 2'd0,
		REG_MESSAGE_LENGTH = 2'd1,
		REG_CHECK_POLY     = 2'd2
	} reg_idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic shift;
		logic emit;
	} ccse_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;
	} ccse_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ccse_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder controller
// Sequences one message through load, parity shifts and result strobe.
// ----------------------------------------------------------------------------
module ccse_ctrl
	import ccse_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire ccse_status_t status,
	output logic              busy,
	output ccse_cmd_t         cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd.load  = 1'b0;
		cmd.shift = 1'b0;
		cmd.emit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (status.last) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					cmd.shift = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q == ST_RUN);

endmodule
`default_nettype wire

// ===== hw/rtl/ccse_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder datapath
// Holds the codeword shift register, the aligned check taps and the parity
// counter, and registers the result.
// ----------------------------------------------------------------------------
module ccse_dpath
	import ccse_pkg::*;
#(
	parameter int MAX_N = CCSE_MAX_N
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [CCSE_N_W-1:0]    code_length,
	input  wire logic [CCSE_K_W-1:0]    message_length,
	input  wire logic [CCSE_POLY_W-1:0] check_poly,
	input  wire logic [CCSE_MSG_W-1:0]  message,
	input  wire ccse_cmd_t              cmd,
	output ccse_status_t                status,
	output logic                        done,
	output logic [CCSE_CW_W-1:0]        codeword,
	output logic                        bad_config
);

	localparam int X_W   = MAX_N;
	localparam int H_W   = MAX_N - 1;
	localparam int CNT_W = $clog2(MAX_N);

	logic [X_W-1:0]         x_q;
	logic [H_W-1:0]         taps_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   bad_q;
	logic                   done_q;
	logic [CCSE_CW_W-1:0]   codeword_q;
	logic                   bad_config_q;

	logic                   bad_d;
	logic [CCSE_N_W-1:0]    r_d;
	logic [CCSE_POLY_W-1:0] k_mask;
	logic [CCSE_POLY_W-1:0] h_rev;
	logic [CCSE_POLY_W-1:0] taps_full;
	logic                   fb;

	always_comb begin
		bad_d = (message_length == '0) ||
			({1'b0, message_length} >= code_length) ||
			(code_length > CCSE_N_W'(MAX_N));
		r_d    = code_length - {1'b0, message_length};
		k_mask = ~({CCSE_POLY_W{1'b1}} << message_length);
		for (int i = 0; i < CCSE_POLY_W; i++) begin
			h_rev[i] = check_poly[CCSE_POLY_W-1-i];
		end
		// Tap i multiplies window bit i, which is h at index k-1-i.
		taps_full = (h_rev >> (CCSE_N_W'(CCSE_POLY_W) - {1'b0, message_length}))
			& k_mask;
	end

	assign fb = ^(taps_q & x_q[H_W-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= X_W'(message & k_mask);
			taps_q <= H_W'(taps_full);
			cnt_q  <= CNT_W'(r_d);
			bad_q  <= bad_d;
		end else if (cmd.shift) begin
			x_q   <= {x_q[X_W-2:0], fb};
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (cmd.emit) begin
			codeword_q   <= bad_q ? '0 : CCSE_CW_W'(x_q);
			bad_config_q <= bad_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	assign status.last = bad_q || (cnt_q == '0);
	assign done        = done_q;
	assign codeword    = codeword_q;
	assign bad_config  = bad_config_q;

endmodule
`default_nettype wire

// ===== hw/rtl/cyclic_code_systematic_encoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cyclic code systematic encoder
// Encodes k-bit messages into n-bit codewords of a binary cyclic code given
// by its parity-check polynomial, computing one parity bit per cycle.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// config    in/out     psel/penable/pwrite/pready paddr, pwdata, prdata
// command   in         start while busy is low    message
// result    out        done, one cycle            codeword, bad_config
//
// A beat on the command channel is taken at a rising edge with start high
// and busy low. With valid settings the result strobe follows the n-k parity
// shifts and a final emit, and busy drops together with it, so a new message
// is taken only once the last one is done. The parity counter walks the n-k
// positions one per cycle. With unusable settings the emit comes
// straight after the load. Reset is asynchronous and active low; it
// restores n=7, k=4, h=7 and leaves the block idle. The receiver cannot
// stall: each result is valid for exactly the one cycle that done is high.
// Settings must only be written while the block is idle.
//
module cyclic_code_systematic_encoder_top
	import ccse_pkg::*;
#(
	parameter int MAX_N = CCSE_MAX_N
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Configuration port.
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [CCSE_ADDR_W-1:0] paddr,
	input  wire logic [CCSE_DATA_W-1:0] pwdata,
	output logic      [CCSE_DATA_W-1:0] prdata,
	output logic                        pready,
	// Command channel.
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [CCSE_MSG_W-1:0]  message,
	// Result channel.
	output logic                        done,
	output logic      [CCSE_CW_W-1:0]   codeword,
	output logic                        bad_config
);

	logic [CCSE_N_W-1:0]    code_length_q;
	logic [CCSE_K_W-1:0]    message_length_q;
	logic [CCSE_POLY_W-1:0] check_poly_q;
	logic                   cfg_wr;
	reg_idx_t               reg_idx;
	ccse_cmd_t              cmd;
	ccse_status_t           status;

	// Registers sit eight bytes apart, so the index is address bits four and
	// three; the low byte-lane bits are ignored.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[CCSE_ADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_length_q    <= CCSE_N_W'(7);
			message_length_q <= CCSE_K_W'(4);
			check_poly_q     <= CCSE_POLY_W'(7);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_CODE_LENGTH:    code_length_q    <= pwdata[CCSE_N_W-1:0];
				REG_MESSAGE_LENGTH: message_length_q <= pwdata[CCSE_K_W-1:0];
				REG_CHECK_POLY:     check_poly_q     <= pwdata[CCSE_POLY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read data is returned combinationally in the access cycle.
	always_comb begin
		unique case (reg_idx)
			REG_CODE_LENGTH:    prdata = CCSE_DATA_W'(code_length_q);
			REG_MESSAGE_LENGTH: prdata = CCSE_DATA_W'(message_length_q);
			REG_CHECK_POLY:     prdata = CCSE_DATA_W'(check_poly_q);
			default:            prdata = '0;
		endcase
	end

	// The controller steps the datapath through load, n-k parity shifts (skipped
	// on bad settings) and an emit that registers the codeword and raises done.
	ccse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	ccse_dpath #(
		.MAX_N (MAX_N)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.code_length    (code_length_q),
		.message_length (message_length_q),
		.check_poly     (check_poly_q),
		.message        (message),
		.cmd            (cmd),
		.status         (status),
		.done           (done),
		.codeword       (codeword),
		.bad_config     (bad_config)
	);

	// Unusable settings always come out with an all-zero codeword.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!bad_config || codeword == '0))
		else $error("bad_config result carries a non-zero codeword");

	// An accepted beat keeps the block busy in the following cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	// The result strobe lasts one cycle and coincides with busy falling.
	a_done_fell: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $fell(busy))
		else $error("done raised without busy falling");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

endmodule
`default_nettype wire

// ===== bench/tb_cyclic_code_systematic_encoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cyclic code systematic encoder testbench
// Drives messages into the encoder under a range of code settings and
// checks every codeword and bad_config flag against a predictor of its own.
// Settings are written over the register port and read back.
// ----------------------------------------------------------------------------
module tb_cyclic_code_systematic_encoder_top;
	import ccse_pkg::*;

	// Index 3 is decoded by nothing, so a write there must leave all settings alone.
	localparam logic [CCSE_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int N_ITEMS      = 850;
	localparam int MAX_GAP      = 17;
	localparam int DRAIN_LIMIT  = 5000;
	// This tail outlasts the longest encode, so it covers any late strobe.
	localparam int TAIL_CYCLES  = 70;
	localparam logic [CCSE_MSG_W-1:0] ALL_ONES = {CCSE_MSG_W{1'b1}};

	// The scoreboard keeps its own copy of the settings. It encodes each
	// accepted message and queues the result for the done strobe to check.
	class codeword_scoreboard;
		logic [CCSE_N_W-1:0]    code_len;
		logic [CCSE_K_W-1:0]    msg_len;
		logic [CCSE_POLY_W-1:0] poly;
		logic [CCSE_CW_W-1:0]   expected_words[$];
		logic                   expected_bad[$];
		int                     errors;

		function new();
			code_len = CCSE_N_W'(7);
			msg_len  = CCSE_K_W'(4);
			poly     = CCSE_POLY_W'(7);
			errors   = 0;
		endfunction

		function void set_reg(input logic [CCSE_IDX_W-1:0] idx, input logic [63:0] value);
			case (idx)
				REG_CODE_LENGTH:    code_len = value[CCSE_N_W-1:0];
				REG_MESSAGE_LENGTH: msg_len  = value[CCSE_K_W-1:0];
				REG_CHECK_POLY:     poly     = value[CCSE_POLY_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [63:0] reg_value(input logic [CCSE_IDX_W-1:0] idx);
			case (idx)
				REG_CODE_LENGTH:    return 64'(code_len);
				REG_MESSAGE_LENGTH: return 64'(msg_len);
				default:            return 64'(poly);
			endcase
		endfunction

		function void check_reg(input logic [CCSE_IDX_W-1:0] idx, input logic [63:0] got);
			if (got !== reg_value(idx)) begin
				errors++;
				$display("%0t: register %0d read-back mismatch, expected %h, got %h",
					$time, idx, reg_value(idx), got);
			end
		endfunction

		// Message bits sit above the parity; parity is filled from the top
		// parity position downwards by the LFSR recurrence over h(x).
		function void encode_message(input logic [CCSE_MSG_W-1:0] msg,
			output logic [CCSE_CW_W-1:0] cw, output logic bad);
			int n;
			int k;
			int r;
			logic [63:0] word;
			logic b;
			n = int'(code_len);
			k = int'(msg_len);
			if (k < 1 || k >= n || n > CCSE_MAX_N) begin
				cw  = '0;
				bad = 1'b1;
				return;
			end
			r = n - k;
			word = (64'(msg) & ((64'd1 << k) - 64'd1)) << r;
			for (int p = r - 1; p >= 0; p--) begin
				b = 1'b0;
				for (int j = 0; j < k; j++)
					if (poly[j])
						b ^= word[p + k - j];
				word[p] = b;
			end
			if (n < 64)
				word &= (64'd1 << n) - 64'd1;
			cw  = word;
			bad = 1'b0;
		endfunction

		function void note_message(input logic [CCSE_MSG_W-1:0] msg);
			logic [CCSE_CW_W-1:0] cw;
			logic bad;
			encode_message(msg, cw, bad);
			expected_words = {expected_words, cw};
			expected_bad   = {expected_bad, bad};
		endfunction

		function void check_result(input logic [CCSE_CW_W-1:0] cw, input logic bad);
			logic [CCSE_CW_W-1:0] exp_cw;
			logic exp_bad;
			if (expected_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got codeword %h bad_config %b",
					$time, cw, bad);
				return;
			end
			exp_cw  = expected_words.pop_front();
			exp_bad = expected_bad.pop_front();
			if (cw !== exp_cw) begin
				errors++;
				$display("%0t: codeword mismatch, expected %h, got %h", $time, exp_cw, cw);
			end
			if (bad !== exp_bad) begin
				errors++;
				$display("%0t: bad_config mismatch, expected %b, got %b", $time, exp_bad, bad);
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void flush_leftover();
			while (expected_words.size() > 0) begin
				errors++;
				$display("%0t: missing result, expected codeword %h bad_config %b, got none",
					$time, expected_words.pop_front(), expected_bad.pop_front());
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [CCSE_ADDR_W-1:0] paddr;
	logic [CCSE_DATA_W-1:0] pwdata;
	logic [CCSE_DATA_W-1:0] prdata;
	logic                   pready;
	logic                   start;
	logic                   busy;
	logic [CCSE_MSG_W-1:0]  message;
	logic                   done;
	logic [CCSE_CW_W-1:0]   codeword;
	logic                   bad_config;

	codeword_scoreboard sb;

	cyclic_code_systematic_encoder_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.start      (start),
		.busy       (busy),
		.message    (message),
		.done       (done),
		.codeword   (codeword),
		.bad_config (bad_config)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Everything is sampled at the rising edge, before the driver's nonblocking
	// updates land. The result is checked before the new beat is noted, as a
	// result and a fresh command beat can share an edge when busy drops.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(codeword, bad_config);
			if (start && !busy)
				sb.note_message(message);
		end
	end

	// All tasks below are entered just after a rising edge and return just
	// after one, so every drive is a single nonblocking update at an edge.
	task automatic write_reg(input logic [CCSE_IDX_W-1:0] idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_reg(idx, value);
	endtask

	task automatic read_reg(input logic [CCSE_IDX_W-1:0] idx);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 3'b000};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.check_reg(idx, prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Writes n, k and h with random rubbish in the unused upper bits of each
	// data word, then reads all three back.
	task automatic set_code(input int n, input int k, input logic [CCSE_POLY_W-1:0] h);
		logic [63:0] word;
		word = {$urandom, $urandom};
		word[CCSE_N_W-1:0] = CCSE_N_W'(n);
		write_reg(REG_CODE_LENGTH, word);
		word = {$urandom, $urandom};
		word[CCSE_K_W-1:0] = CCSE_K_W'(k);
		write_reg(REG_MESSAGE_LENGTH, word);
		word = {$urandom, $urandom};
		word[CCSE_POLY_W-1:0] = h;
		write_reg(REG_CHECK_POLY, word);
		read_reg(REG_CODE_LENGTH);
		read_reg(REG_MESSAGE_LENGTH);
		read_reg(REG_CHECK_POLY);
	endtask

	// Start is left high after the beat is taken; the next call either keeps
	// it high for a back-to-back beat or lowers it for the gap.
	task automatic send_message(input logic [CCSE_MSG_W-1:0] msg, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		message <= msg;
		do @(posedge clk); while (busy);
	endtask

	// Lowers start and waits for every outstanding codeword. Busy falls with
	// done, so the block is idle then; a few spare cycles are allowed anyway.
	task automatic drain();
		int cnt;
		cnt = 0;
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0 && cnt < DRAIN_LIMIT) begin
			@(posedge clk);
			cnt++;
		end
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [CCSE_MSG_W-1:0] random_message();
		logic [63:0] word;
		word = {$urandom, $urandom};
		return word[CCSE_MSG_W-1:0];
	endfunction

	// Directed beats for one setting: all message bits set, then one random message.
	task automatic try_setting(input int n, input int k, input logic [CCSE_POLY_W-1:0] h);
		set_code(n, k, h);
		send_message(ALL_ONES, 0);
		send_message(random_message(), 0);
		drain();
	endtask

	initial begin
		int sent;
		int len;
		int n;
		int k;
		bit idle_on;
		logic [CCSE_POLY_W-1:0] h;
		logic [63:0] junk;

		sb      = new();
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		start   = 1'b0;
		message = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings give the (7,4) Hamming code; check them and encode a
		// few messages, including one with bits above k that must be ignored.
		read_reg(REG_CODE_LENGTH);
		read_reg(REG_MESSAGE_LENGTH);
		read_reg(REG_CHECK_POLY);
		send_message('0, 0);
		send_message(63'h8, 0);
		send_message(ALL_ONES, 0);
		send_message(63'h5A5A_5A5A_5A5A_5A50, 0);
		drain();

		// A write to the spare index must change nothing.
		junk = {$urandom, $urandom};
		write_reg(REG_SPARE, junk);
		read_reg(REG_CODE_LENGTH);
		read_reg(REG_MESSAGE_LENGTH);
		read_reg(REG_CHECK_POLY);
		send_message(random_message(), 0);
		drain();

		// Extremes of n and k, then each way the settings can be unusable:
		// zero message length, k equal to n, k above n and n beyond the maximum.
		try_setting(64, 63, {CCSE_POLY_W{1'b1}});
		try_setting(64, 1, 63'h1);
		try_setting(2, 1, 63'h1);
		try_setting(7, 0, 63'h7);
		try_setting(5, 5, 63'h3);
		try_setting(3, 10, 63'h155);
		try_setting(127, 4, 63'h7);
		try_setting(65, 63, {CCSE_POLY_W{1'b1}});

		// Random phases. Most settings are usable; one in eight is drawn from
		// the whole register range and is usually unusable. Some phases run
		// with no gaps at all, and now and then the sender stops until every
		// codeword has come back.
		sent = 0;
		while (sent < N_ITEMS) begin
			if ($urandom_range(0, 7) == 0) begin
				n = $urandom_range(0, 127);
				k = $urandom_range(0, 63);
			end else begin
				n = $urandom_range(2, 64);
				k = $urandom_range(1, n - 1);
			end
			case ($urandom_range(0, 5))
				0:       h = '0;
				1:       h = {CCSE_POLY_W{1'b1}};
				default: h = random_message();
			endcase
			set_code(n, k, h);
			len = $urandom_range(20, 60);
			idle_on = ($urandom_range(0, 3) != 0);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 39) == 0) begin
					start <= 1'b0;
					@(posedge clk);
					while (sb.pending() > 0)
						@(posedge clk);
				end
				send_message(random_message(), idle_on ? $urandom_range(0, MAX_GAP) : 0);
			end
			sent += len;
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		sb.flush_leftover();
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// The timeout lies far beyond the slowest correct run.
	initial begin
		#20000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/ccse_pkg.sv
hw/rtl/ccse_ctrl.sv
hw/rtl/ccse_dpath.sv
hw/rtl/cyclic_code_systematic_encoder_top.sv
bench/tb_cyclic_code_systematic_encoder_top.sv
